// File: rtl/core/pd_pkg.sv
// Shared constants and types for the perspective divide and viewport map.
// No dependencies; every other file in rtl/core refers to this package.
`timescale 1ns / 1ps
`default_nettype none
package pd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam int MAG_W         = 64;
  localparam int DEN_W         = 32;
  localparam int Q_W           = 42;
  localparam int DIV_STEPS     = 3;
  localparam int DIV_STG       = Q_W / DIV_STEPS;
  localparam int CAP_W         = 41;
  localparam int RES_W         = 43;
  localparam int FRONT_LAT     = 3;
  localparam int LAT           = FRONT_LAT + DIV_STG + 2;

  localparam logic [CAP_W-1:0] QUOT_CAP = CAP_W'(1) << 40;

  typedef enum logic [2:0] {
    REG_X_SCALE      = 3'd0,
    REG_X_SHEAR      = 3'd1,
    REG_X_OFFSET     = 3'd2,
    REG_Y_SCALE      = 3'd3,
    REG_Y_SHEAR      = 3'd4,
    REG_Y_OFFSET     = 3'd5,
    REG_DEPTH_SCALE  = 3'd6,
    REG_DEPTH_OFFSET = 3'd7
  } reg_idx_t;

  // Per-vertex flags that ride alongside the divider
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_d;
    logic zero;
    logic last;
  } pd_side_t;

endpackage
`default_nettype wire

// File: rtl/core/pd_front.sv
// Front end: products, signed sums and magnitudes feeding the dividers.
// Three register stages; uses pd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pd_front #(
  parameter int FRAC_BITS = pd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic signed [31:0]              vertex_x,
  input  wire logic signed [31:0]              vertex_y,
  input  wire logic signed [31:0]              vertex_z,
  input  wire logic                            last_in,
  input  wire logic signed [31:0]              x_scale,
  input  wire logic signed [31:0]              x_shear,
  input  wire logic signed [31:0]              y_scale,
  input  wire logic signed [31:0]              y_shear,
  input  wire logic signed [31:0]              depth_scale,
  input  wire logic signed [31:0]              depth_offset,
  output logic             [pd_pkg::MAG_W-1:0] num_x,
  output logic             [pd_pkg::MAG_W-1:0] num_y,
  output logic             [pd_pkg::MAG_W-1:0] num_d,
  output logic             [pd_pkg::DEN_W-1:0] den,
  output pd_pkg::pd_side_t                     side
);

  logic signed [63:0] px_a, px_b, py_a, py_b, pd_a, pd_b;
  logic signed [31:0] z1, z2;
  logic               zero1, zero2, last1, last2;
  logic signed [64:0] sx, sy, sd;
  logic        [64:0] ax, ay, ad;
  logic        [31:0] az;
  logic               zneg;

  // Stage 1: one multiply per term; the depth offset is shifted into place
  always_ff @(posedge clk) begin
    if (en) begin
      px_a  <= vertex_x * x_scale;
      px_b  <= vertex_z * x_shear;
      py_a  <= vertex_y * y_scale;
      py_b  <= vertex_z * y_shear;
      pd_a  <= vertex_z * depth_scale;
      pd_b  <= {{32{depth_offset[31]}}, depth_offset} <<< FRAC_BITS;
      z1    <= vertex_z;
      zero1 <= (vertex_z == 32'sd0);
      last1 <= last_in;
    end
  end

  // Stage 2: exact sums of products
  always_ff @(posedge clk) begin
    if (en) begin
      sx    <= {px_a[63], px_a} + {px_b[63], px_b};
      sy    <= {py_a[63], py_a} + {py_b[63], py_b};
      sd    <= {pd_a[63], pd_a} + {pd_b[63], pd_b};
      z2    <= z1;
      zero2 <= zero1;
      last2 <= last1;
    end
  end

  // Stage 3: take magnitudes, pick divisor, settle quotient signs
  always_comb begin
    ax   = sx[64] ? 65'(-sx) : 65'(sx);
    ay   = sy[64] ? 65'(-sy) : 65'(sy);
    ad   = sd[64] ? 65'(-sd) : 65'(sd);
    zneg = z2[31];
    az   = zneg ? 32'(-z2) : 32'(z2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_x      <= zero2 ? (ax[63:0] >> FRAC_BITS) : ax[63:0];
      num_y      <= zero2 ? (ay[63:0] >> FRAC_BITS) : ay[63:0];
      num_d      <= ad[63:0];
      den        <= zero2 ? 32'd1 : az;
      side.neg_x <= sx[64] ^ (!zero2 && !zneg);
      side.neg_y <= sy[64] ^ (!zero2 && !zneg);
      side.neg_d <= sd[64] ^ zneg;
      side.zero  <= zero2;
      side.last  <= last2;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pd_divider.sv
// Pipelined restoring divider: 64-bit magnitude by 32-bit magnitude,
// quotient of Q_W bits plus an overflow flag. Uses pd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pd_divider (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [pd_pkg::MAG_W-1:0] num,
  input  wire logic [pd_pkg::DEN_W-1:0] den,
  output logic      [pd_pkg::Q_W-1:0]   quot,
  output logic                          ovf
);

  localparam int QW = pd_pkg::Q_W;
  localparam int DW = pd_pkg::DEN_W;
  localparam int NS = pd_pkg::DIV_STG;
  localparam int ST = pd_pkg::DIV_STEPS;
  localparam int TW = pd_pkg::MAG_W - QW;

  logic [DW-1:0] rem  [NS+1];
  logic [QW-1:0] lowb [NS+1];
  logic [QW-1:0] qacc [NS+1];
  logic [DW-1:0] dsor [NS+1];
  logic          ovfp [NS+1];

  // Stage 0: check the high part against the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= DW'(num[pd_pkg::MAG_W-1:QW]);
      ovfp[0] <= DW'(num[pd_pkg::MAG_W-1:QW]) >= den;
      lowb[0] <= num[QW-1:0];
      qacc[0] <= '0;
      dsor[0] <= den;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_stage
    logic [DW-1:0] r;
    logic [QW-1:0] l, q;
    logic [DW:0]   t;

    // Advance several quotient bits per stage
    always_comb begin
      r = rem[k-1];
      l = lowb[k-1];
      q = qacc[k-1];
      t = '0;
      for (int i = 0; i < ST; i++) begin
        t = {r, l[QW-1]};
        l = {l[QW-2:0], 1'b0};
        if (t >= {1'b0, dsor[k-1]}) begin
          r = DW'(t - {1'b0, dsor[k-1]});
          q = {q[QW-2:0], 1'b1};
        end else begin
          r = t[DW-1:0];
          q = {q[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= r;
        lowb[k] <= l;
        qacc[k] <= q;
        dsor[k] <= dsor[k-1];
        ovfp[k] <= ovfp[k-1];
      end
    end
  end

  assign quot = qacc[NS];
  assign ovf  = ovfp[NS];

  // TW names the width of the overflow check
  if (TW > DW) begin : g_bad
    $error("numerator high part wider than divisor");
  end

endmodule
`default_nettype wire

// File: rtl/core/pd_finish.sv
// Output stage for one value: clamp the quotient, apply sign and offset,
// saturate to 32 bits and register. Uses pd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pd_finish (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [pd_pkg::Q_W-1:0] quot,
  input  wire logic                   ovf,
  input  wire logic                   neg,
  input  wire logic                   force_zero,
  input  wire logic signed [31:0]     offset,
  output logic signed [31:0]          res,
  output logic                        sat
);

  localparam int RW = pd_pkg::RES_W;
  localparam logic signed [RW-1:0] VMAX = RW'(32'sh7fffffff);
  localparam logic signed [RW-1:0] VMIN = -(RW'(1) <<< 31);

  logic [pd_pkg::CAP_W-1:0] m;
  logic signed [RW-1:0]     mv, v;

  // Clamp, sign, offset
  always_comb begin
    m  = (ovf || quot > pd_pkg::Q_W'(pd_pkg::QUOT_CAP)) ? pd_pkg::QUOT_CAP
                                                        : quot[pd_pkg::CAP_W-1:0];
    mv = $signed({2'b00, m});
    v  = (neg ? -mv : mv) + RW'(offset);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (force_zero) begin
        res <= '0;
        sat <= 1'b0;
      end else if (v > VMAX) begin
        res <= 32'sh7fffffff;
        sat <= 1'b1;
      end else if (v < VMIN) begin
        res <= 32'sh80000000;
        sat <= 1'b1;
      end else begin
        res <= v[31:0];
        sat <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/perspective_divide_viewport_map.sv
// Each vertex passes pd_front, the three dividers and pd_finish, all registered.
// Throughput: one vertex per cycle; the whole pipeline holds while the
// output is valid and stalled. The dividers resolve 3 quotient bits per stage.
// Reset clears the valid bits and loads register defaults (scales 1.0).
// Uses pd_pkg, pd_front, pd_divider, pd_finish.
`timescale 1ns / 1ps
`default_nettype none
module perspective_divide_viewport_map #(
  parameter int FRAC_BITS = pd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [pd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [31:0]        vertex_x,
  input  wire logic signed [31:0]        vertex_y,
  input  wire logic signed [31:0]        vertex_z,
  input  wire logic                      last_in,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [31:0]             screen_x,
  output logic signed [31:0]             screen_y,
  output logic signed [31:0]             depth_out,
  output logic                           zero_depth,
  output logic                           saturated,
  output logic                           last_out
);

  localparam int LAT = pd_pkg::LAT;
  localparam int NS  = pd_pkg::DIV_STG;
  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  logic [31:0] regs [pd_pkg::NUM_REGS];
  logic [2:0]  widx;
  logic        en;
  logic [LAT-1:0] vld;

  logic [pd_pkg::MAG_W-1:0] num_x, num_y, num_d;
  logic [pd_pkg::DEN_W-1:0] den;
  pd_pkg::pd_side_t         side_f;
  pd_pkg::pd_side_t         side_p [NS+1];
  logic [pd_pkg::Q_W-1:0]   q_x, q_y, q_d;
  logic                     o_x, o_y, o_d, s_x, s_y, s_d;

  // Configuration registers
  assign pready = 1'b1;
  assign widx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[pd_pkg::REG_X_SCALE]      <= ONE;
      regs[pd_pkg::REG_X_SHEAR]      <= '0;
      regs[pd_pkg::REG_X_OFFSET]     <= '0;
      regs[pd_pkg::REG_Y_SCALE]      <= ONE;
      regs[pd_pkg::REG_Y_SHEAR]      <= '0;
      regs[pd_pkg::REG_Y_OFFSET]     <= '0;
      regs[pd_pkg::REG_DEPTH_SCALE]  <= ONE;
      regs[pd_pkg::REG_DEPTH_OFFSET] <= '0;
    end else if (psel && penable && pwrite) begin
      regs[widx] <= pwdata;
    end
  end

  assign prdata = regs[widx];

  // Hold the whole pipeline while the result waits
  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  pd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .en(en),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z), .last_in(last_in),
    .x_scale($signed(regs[pd_pkg::REG_X_SCALE])),
    .x_shear($signed(regs[pd_pkg::REG_X_SHEAR])),
    .y_scale($signed(regs[pd_pkg::REG_Y_SCALE])),
    .y_shear($signed(regs[pd_pkg::REG_Y_SHEAR])),
    .depth_scale($signed(regs[pd_pkg::REG_DEPTH_SCALE])),
    .depth_offset($signed(regs[pd_pkg::REG_DEPTH_OFFSET])),
    .num_x(num_x), .num_y(num_y), .num_d(num_d), .den(den), .side(side_f)
  );

  pd_divider u_div_x (.clk(clk), .en(en), .num(num_x), .den(den), .quot(q_x), .ovf(o_x));
  pd_divider u_div_y (.clk(clk), .en(en), .num(num_y), .den(den), .quot(q_y), .ovf(o_y));
  pd_divider u_div_d (.clk(clk), .en(en), .num(num_d), .den(den), .quot(q_d), .ovf(o_d));

  // Delay the flags to match the divider
  always_ff @(posedge clk) begin
    if (en) begin
      side_p[0] <= side_f;
      for (int i = 1; i <= NS; i++) side_p[i] <= side_p[i-1];
    end
  end

  pd_finish u_fin_x (
    .clk(clk), .en(en), .quot(q_x), .ovf(o_x), .neg(side_p[NS].neg_x), .force_zero(1'b0),
    .offset($signed(regs[pd_pkg::REG_X_OFFSET])), .res(screen_x), .sat(s_x)
  );
  pd_finish u_fin_y (
    .clk(clk), .en(en), .quot(q_y), .ovf(o_y), .neg(side_p[NS].neg_y), .force_zero(1'b0),
    .offset($signed(regs[pd_pkg::REG_Y_OFFSET])), .res(screen_y), .sat(s_y)
  );
  pd_finish u_fin_d (
    .clk(clk), .en(en), .quot(q_d), .ovf(o_d), .neg(side_p[NS].neg_d),
    .force_zero(side_p[NS].zero), .offset(32'sd0), .res(depth_out), .sat(s_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      zero_depth <= side_p[NS].zero;
      last_out   <= side_p[NS].last;
    end
  end

  assign saturated = s_x | s_y | s_d;

  // Checks
  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_depth |-> depth_out == 32'sd0)
    else $error("zero depth with nonzero depth_out");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (screen_x == 32'sh7fffffff || screen_x == 32'sh80000000 ||
       screen_y == 32'sh7fffffff || screen_y == 32'sh80000000 ||
       depth_out == 32'sh7fffffff || depth_out == 32'sh80000000))
    else $error("saturated flag without a clamped value");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted vertex lost at pipeline entry");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while held");

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for perspective_divide_viewport_map: APB register setup,
// random vertex streams with idling, output backpressure. Needs pd_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;

  localparam int FB = 16;
  localparam int WATCH_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [pd_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] vertex_x = '0, vertex_y = '0, vertex_z = '0;
  logic last_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] screen_x, screen_y, depth_out;
  logic zero_depth, saturated, last_out;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] dz;
    logic zero;
    logic sat;
    logic last;
  } vtx_result_t;

  vtx_result_t expected_q[$];
  logic signed [31:0] regs_shadow [pd_pkg::NUM_REGS];
  int errors = 0;
  int vertices_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit hold_out = 1'b0;
  bit rand_out = 1'b1;

  perspective_divide_viewport_map i_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Clamp a signed-magnitude quotient, add the offset, saturate to 32 bits
  function automatic logic [31:0] clamp_add(logic qneg, logic [127:0] qmag,
                                            longint offs, ref logic sat);
    longint v;
    logic [127:0] m;
    m = (qmag > (128'd1 << 40)) ? (128'd1 << 40) : qmag;
    v = qneg ? -longint'(m[63:0]) : longint'(m[63:0]);
    v += offs;
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      sat = 1'b1;
    end
    if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      sat = 1'b1;
    end
    return v[31:0];
  endfunction

  // Project one axis: (c*scale + z*shear) / -z + offset, or rescale when z is 0
  function automatic logic [31:0] axis_map(logic signed [31:0] c, logic signed [31:0] z,
      logic signed [31:0] scale, logic signed [31:0] shear, logic signed [31:0] offs,
      ref logic sat);
    logic signed [127:0] num;
    logic [127:0] mag, zmag, q;
    logic nneg;
    num = 128'(c) * 128'(scale) + 128'(z) * 128'(shear);
    nneg = num < 0;
    mag = nneg ? 128'(-num) : 128'(num);
    if (z == 0) begin
      q = mag >> FB;
      return clamp_add(nneg && q != 0, q, longint'(offs), sat);
    end
    zmag = (z < 0) ? 128'(-128'(z)) : 128'(z);
    q = mag / zmag;
    return clamp_add((nneg != !(z < 0)) && q != 0, q, longint'(offs), sat);
  endfunction

  function automatic vtx_result_t project_vertex(logic signed [31:0] x,
      logic signed [31:0] y, logic signed [31:0] z, logic last);
    vtx_result_t r;
    logic signed [127:0] num;
    logic [127:0] mag, zmag, q;
    logic sat;
    sat = 1'b0;
    r.sx = axis_map(x, z, regs_shadow[pd_pkg::REG_X_SCALE], regs_shadow[pd_pkg::REG_X_SHEAR],
                    regs_shadow[pd_pkg::REG_X_OFFSET], sat);
    r.sy = axis_map(y, z, regs_shadow[pd_pkg::REG_Y_SCALE], regs_shadow[pd_pkg::REG_Y_SHEAR],
                    regs_shadow[pd_pkg::REG_Y_OFFSET], sat);
    if (z == 0) begin
      r.dz = '0;
    end else begin
      num = 128'(z) * 128'(regs_shadow[pd_pkg::REG_DEPTH_SCALE])
          + (128'(regs_shadow[pd_pkg::REG_DEPTH_OFFSET]) <<< FB);
      mag = (num < 0) ? 128'(-num) : 128'(num);
      zmag = (z < 0) ? 128'(-128'(z)) : 128'(z);
      q = mag / zmag;
      r.dz = clamp_add(((num < 0) != (z < 0)) && q != 0, q, 0, sat);
    end
    r.zero = (z == 0);
    r.sat = sat;
    r.last = last;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR @%0t result %0d %s: got %h want %h", $realtime, results_seen,
             what, got, want);
    errors++;
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(pd_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= pd_pkg::ADDR_W'(4 * int'(idx));
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    regs_shadow[idx] = val;
  endtask

  // Offer one vertex, after a random gap when gaps is set; return once it transfers
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last,
                             bit gaps = 1'b1);
    int gap;
    gap = gaps ? ((($urandom & 3) == 0) ? 0 : $urandom_range(0, 17)) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    vertex_x <= x;
    vertex_y <= y;
    vertex_z <= z;
    last_in <= last;
    expected_q.push_back(project_vertex(x, y, z, last));
    do @(posedge clk); while (in_stall);
    vertices_sent++;
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (pd_pkg::LAT + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20 << FB)) - (10 << FB));
      2: return {{16{r[31]}}, r[15:0]};
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 400 << FB)) - (200 << FB));
    endcase
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    vtx_result_t w;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("ERROR @%0t unexpected result", $realtime);
        errors++;
      end else begin
        w = expected_q.pop_front();
        if (screen_x !== w.sx) report_mismatch("screen_x", screen_x, w.sx);
        if (screen_y !== w.sy) report_mismatch("screen_y", screen_y, w.sy);
        if (depth_out !== w.dz) report_mismatch("depth_out", depth_out, w.dz);
        if (zero_depth !== w.zero)
          report_mismatch("zero_depth", 32'(zero_depth), 32'(w.zero));
        if (saturated !== w.sat)
          report_mismatch("saturated", 32'(saturated), 32'(w.sat));
        if (last_out !== w.last)
          report_mismatch("last_out", 32'(last_out), 32'(w.last));
      end
    end
  end

  // Receiver stall: random stretches, held off for a long stretch, or none when rand_out is clear
  initial begin
    int n;
    forever begin
      if (hold_out) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end else if (rand_out && ($urandom & 1)) begin
        n = $urandom_range(0, 17);
        out_stall <= (n != 0);
        repeat (n) @(posedge clk);
        if (n != 0) out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || expected_q.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("perspective_divide_viewport_map: mismatch");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_vertex(32'h0001_0000, 32'h0002_0000, 32'hffff_0000, 1'b0);
    send_vertex(32'h0003_0000, 32'hfffd_0000, 32'h0, 1'b1);
    drain();
  endtask

  task automatic test_directed();
    write_reg(pd_pkg::REG_X_SCALE, 32'h0002_0000);
    write_reg(pd_pkg::REG_X_SHEAR, 32'hffff_8000);
    write_reg(pd_pkg::REG_X_OFFSET, 32'h0140_0000);
    write_reg(pd_pkg::REG_Y_SCALE, 32'hfffe_0000);
    write_reg(pd_pkg::REG_Y_SHEAR, 32'h0000_4000);
    write_reg(pd_pkg::REG_Y_OFFSET, 32'h00f0_0000);
    write_reg(pd_pkg::REG_DEPTH_SCALE, 32'h0001_8000);
    write_reg(pd_pkg::REG_DEPTH_OFFSET, 32'hfffc_0000);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0);
    send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1);
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h0, 1'b0);
    send_vertex(32'h80000000, 32'h80000000, 32'h0, 1'b1);
    send_vertex(32'h0, 32'h0, 32'h0000_0001, 1'b0);
    send_vertex(32'h7fffffff, 32'h80000000, 32'hffffffff, 1'b1);
    send_vertex(32'hffffffff, 32'h1, 32'h0001_0000, 1'b0);
    send_vertex(32'h0005_0000, 32'hfffb_0000, 32'hfff6_0000, 1'b0);
    drain();
    // extreme register values
    write_reg(pd_pkg::REG_X_SCALE, 32'h7fffffff);
    write_reg(pd_pkg::REG_X_SHEAR, 32'h80000000);
    write_reg(pd_pkg::REG_X_OFFSET, 32'h7fffffff);
    write_reg(pd_pkg::REG_Y_SCALE, 32'h80000000);
    write_reg(pd_pkg::REG_Y_SHEAR, 32'h7fffffff);
    write_reg(pd_pkg::REG_Y_OFFSET, 32'h80000000);
    write_reg(pd_pkg::REG_DEPTH_SCALE, 32'h80000000);
    write_reg(pd_pkg::REG_DEPTH_OFFSET, 32'h7fffffff);
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h1, 1'b0);
    send_vertex(32'h80000000, 32'h80000000, 32'hffffffff, 1'b1);
    send_vertex(32'h0001_0000, 32'hffff_0000, 32'h0, 1'b0);
    send_vertex(32'h0, 32'h0, 32'h7fffffff, 1'b1);
    send_vertex(32'h0, 32'h0, 32'h80000000, 1'b0);
    drain();
  endtask

  task automatic test_random_phase(int count, bit extreme_regs);
    int i;
    for (i = 0; i < pd_pkg::NUM_REGS; i++)
      write_reg(pd_pkg::reg_idx_t'(i), extreme_regs ? $urandom
                : 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB)));
    for (i = 0; i < count; i++)
      send_vertex(rand_coord(), rand_coord(),
                  ($urandom_range(0, 9) == 0) ? 32'h0 : rand_coord(),
                  1'($urandom_range(0, 1)));
    drain();
  endtask

  // Hold the output off while vertices keep coming, so the input stalls
  task automatic test_backpressure();
    int i;
    hold_out = 1'b1;
    fork
      begin
        repeat (120) @(posedge clk);
        hold_out = 1'b0;
      end
      for (i = 0; i < 40; i++)
        send_vertex(rand_coord(), rand_coord(), rand_coord(), i == 39, 1'b0);
    join
    drain();
  endtask

  initial begin
    for (int i = 0; i < pd_pkg::NUM_REGS; i++) regs_shadow[i] = 0;
    regs_shadow[pd_pkg::REG_X_SCALE] = 1 << FB;
    regs_shadow[pd_pkg::REG_Y_SCALE] = 1 << FB;
    regs_shadow[pd_pkg::REG_DEPTH_SCALE] = 1 << FB;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_phase(150, 1'b0);
    test_random_phase(150, 1'b1);
    test_backpressure();
    rand_out = 1'b0;
    test_random_phase(80, 1'b0);
    rand_out = 1'b1;
    test_random_phase(80, 1'b1);
    $display("Sent %0d vertices and checked %0d results over several register settings,",
             vertices_sent, results_seen);
    $display("including zero depth, saturation and a long output hold.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("perspective_divide_viewport_map: match");
    end else begin
      $display("perspective_divide_viewport_map: mismatch");
    end
    $finish;
  end
endmodule
